// ----- rtl/bgd_pkg.sv -----
// Shared types and constants for the button gesture detector.
package bgd_pkg;

   // Command codes carried in the func field.
   localparam logic [1:0] FUNC_POLL = 2'd0;
   localparam logic [1:0] FUNC_TAKE = 2'd1;
   localparam logic [1:0] FUNC_INIT = 2'd2;

   // Event codes.
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SINGLE = 2'd1;
   localparam logic [1:0] EV_DOUBLE = 2'd2;
   localparam logic [1:0] EV_LONG   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [1:0] CSR_DOUBLE_GAP = 2'd2;

   // Configuration reset values in milliseconds.
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [15:0] DOUBLE_GAP_RESET = 16'd400;

   // Gesture phases, one-hot.
   typedef enum logic [4:0] {
      PH_IDLE         = 5'b00001,
      PH_PRESSED      = 5'b00010,
      PH_LONG_HELD    = 5'b00100,
      PH_WAIT_SECOND  = 5'b01000,
      PH_WAIT_RELEASE = 5'b10000
   } phase_type;

   // Input item.
   typedef struct packed {
      logic [1:0]  func;
      logic        raw_pressed;
      logic [31:0] now_ms;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0] event_res;
      logic       active;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] double_gap_time;
   } cfg_type;

   // Debouncer and gesture state.
   typedef struct packed {
      logic        stable_level;
      logic        previous_raw;
      logic [31:0] change_time;
      phase_type   phase;
      logic [31:0] press_time;
      logic [31:0] release_time;
      logic [1:0]  pending_event;
   } state_type;

endpackage

// ----- rtl/bgd_csr.sv -----
// Configuration registers of the button gesture detector.
module bgd_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output bgd_pkg::cfg_type cfg
);
   import bgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes past the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_time   = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_time = csr_wdata;
            CSR_DOUBLE_GAP: cfg_in.double_gap_time = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_RESET;
         cfg_ff.double_gap_time <= DOUBLE_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bgd_core.sv -----
// Next-state and result logic: debouncer followed by the gesture machine.
module bgd_core (
   input  bgd_pkg::cfg_type   cfg,
   input  bgd_pkg::state_type cur,
   input  bgd_pkg::req_type   item,
   output bgd_pkg::state_type nxt,
   output bgd_pkg::rsp_type   result
);
   import bgd_pkg::*;

   logic [31:0] since_change;
   logic [31:0] since_press;
   logic [31:0] since_release;
   logic        settled;
   logic        long_due;
   logic        gap_over;
   logic        rise;
   logic        fall;
   state_type   st;

   // Elapsed times wrap modulo 2^32.
   assign since_change  = item.now_ms - cur.change_time;
   assign since_press   = item.now_ms - cur.press_time;
   assign since_release = item.now_ms - cur.release_time;
   assign settled  = since_change  >= {16'd0, cfg.debounce_time};
   assign long_due = since_press   >= {16'd0, cfg.long_press_time};
   assign gap_over = since_release >= {16'd0, cfg.double_gap_time};

   always_comb begin
      st               = cur;
      rise             = 1'b0;
      fall             = 1'b0;
      result.event_res = EV_NONE;

      case (item.func)
         FUNC_POLL: begin
            // A raw change restarts the settle timer; a steady new level is accepted.
            if (item.raw_pressed != cur.previous_raw) begin
               st.previous_raw = item.raw_pressed;
               st.change_time  = item.now_ms;
            end else if (item.raw_pressed != cur.stable_level && settled) begin
               st.stable_level = item.raw_pressed;
               rise = item.raw_pressed;
               fall = !item.raw_pressed;
            end

            // Gesture machine; a release beats a long timeout on the same poll.
            case (cur.phase)
               PH_PRESSED: begin
                  if (fall) begin
                     st.release_time = item.now_ms;
                     st.phase        = PH_WAIT_SECOND;
                  end else if (long_due) begin
                     st.pending_event = EV_LONG;
                     st.phase         = PH_LONG_HELD;
                  end
               end
               PH_LONG_HELD, PH_WAIT_RELEASE: begin
                  if (fall) st.phase = PH_IDLE;
               end
               PH_WAIT_SECOND: begin
                  if (rise) begin
                     st.pending_event = EV_DOUBLE;
                     st.phase         = PH_WAIT_RELEASE;
                  end else if (gap_over) begin
                     st.pending_event = EV_SINGLE;
                     st.phase         = PH_IDLE;
                  end
               end
               default: begin
                  st.phase = PH_IDLE;
                  if (rise) begin
                     st.press_time = item.now_ms;
                     st.phase      = PH_PRESSED;
                  end
               end
            endcase
         end
         FUNC_TAKE: begin
            // Read and clear the pending event.
            result.event_res = cur.pending_event;
            st.pending_event = EV_NONE;
         end
         FUNC_INIT: begin
            // Resynchronize to the pin; press and release times are kept.
            st.previous_raw  = item.raw_pressed;
            st.stable_level  = item.raw_pressed;
            st.change_time   = item.now_ms;
            st.phase         = PH_IDLE;
            st.pending_event = EV_NONE;
         end
         default: st = cur;
      endcase

      nxt           = st;
      result.active = (st.phase != PH_IDLE) || (st.previous_raw != st.stable_level);
   end

endmodule

// ----- rtl/button_gesture_detector.sv -----
// Top level of the button gesture detector.
// Debounces a sampled button level and reports single, double and long presses.
// An item is registered on acceptance, worked through the debouncer and gesture
// logic once the output register can take it, and its result is then registered
// in the output register, where rsp_valid marks it. One item is taken every
// cycle while the result side keeps up. Throughput is set by the single state
// update per cycle in the core. The input register keeps taking items while a
// finished result waits, until both registers hold an item.
module button_gesture_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bgd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bgd_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import bgd_pkg::*;

   cfg_type   cfg;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_item_ff;
   state_type state_ff;
   state_type state_nxt;
   rsp_type   core_rsp;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      out_ready;
   logic      fire;

   bgd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   bgd_core u_core (
      .cfg    (cfg),
      .cur    (state_ff),
      .item   (s1_item_ff),
      .nxt    (state_nxt),
      .result (core_rsp)
   );

   // Handshake: the item in the input register moves on when the output register frees up.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) s1_valid_in = req_valid;
      rsp_valid_in = rsp_valid_ff;
      if (fire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.stable_level  <= 1'b0;
         state_ff.previous_raw  <= 1'b0;
         state_ff.change_time   <= 32'd0;
         state_ff.phase         <= PH_IDLE;
         state_ff.press_time    <= 32'd0;
         state_ff.release_time  <= 32'd0;
         state_ff.pending_event <= EV_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) state_ff <= state_nxt;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) s1_item_ff <= req_data;
      if (fire) rsp_data_ff <= core_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The input side only stalls while an item is held in the input register.
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with no item held");

   // Taking the event always leaves nothing pending.
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_item_ff.func == FUNC_TAKE) |=> (state_ff.pending_event == EV_NONE))
      else $error("pending event not cleared by take");

   // After a resync the block reports itself inactive.
   a_init_inactive: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_item_ff.func == FUNC_INIT) |=> (rsp_valid && !rsp_data.active))
      else $error("resync result reports activity");
`endif

endmodule

// ----- tb/sv/button_gesture_detector_tb.sv -----
// Self-checking testbench for the button gesture detector: directed rows, then random gestures.
`timescale 1ns / 1ps

module button_gesture_detector_tb;
   import bgd_pkg::*;

   // Command and register codes that the package leaves unnamed.
   localparam logic [1:0] FUNC_NOP   = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int unsigned PHASE_ITEMS = 190;
   localparam int unsigned PHASES      = 8;

   // One directed row: the item and, where it is obvious, its result typed in.
   typedef struct packed {
      req_type    item;
      logic       typed_ok;
      rsp_type    typed_rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Predictor copy of the registers and of the debouncer and gesture state.
   logic [15:0] cfg_debounce;
   logic [15:0] cfg_long;
   logic [15:0] cfg_gap;
   logic        pin_stable;
   logic        pin_prev;
   logic [31:0] pin_change_ms;
   phase_type   ges_phase;
   logic [31:0] ges_press_ms;
   logic [31:0] ges_release_ms;
   logic [1:0]  ges_event;

   // Results still owed by the block, oldest first.
   rsp_type     due_reports [$];

   // Sender and receiver bookkeeping.
   logic        row_has_rsp = 1'b0;
   rsp_type     row_rsp = '0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned mismatch_count = 0;
   logic [31:0] tick_ms = '0;
   logic        raw_level = 1'b0;
   int unsigned stall_mode = 0;
   int unsigned stall_epoch = 0;
   int unsigned stall_burst = 0;

   // Directed rows, run with the reset register values (20, 1000, 400).
   stim_row_type directed_rows [25] = '{
      '{'{FUNC_TAKE, 1'b0, 32'd0},           1'b1, '{EV_NONE, 1'b0}},
      '{'{FUNC_NOP,  1'b1, 32'd3},           1'b1, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'd10},          1'b1, '{EV_NONE, 1'b1}},
      '{'{FUNC_POLL, 1'b1, 32'd30},          1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'd1029},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'd1049},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'd1449},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_TAKE, 1'b0, 32'd1450},        1'b1, '{EV_SINGLE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'd1460},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'd1480},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'd2480},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_TAKE, 1'b1, 32'd2481},        1'b1, '{EV_LONG, 1'b1}},
      '{'{FUNC_POLL, 1'b0, 32'd2500},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'd2520},        1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_INIT, 1'b1, 32'hFFFF_FFFF},   1'b1, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'hFFFF_FFF8},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'h0000_000C},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'h0000_0010},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'h0000_0024},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'h0000_0030},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b0, 32'h0000_0044},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'h0000_0050},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_POLL, 1'b1, 32'h0000_0064},   1'b0, '{EV_NONE, 1'b0}},
      '{'{FUNC_INIT, 1'b0, 32'h0000_0070},   1'b1, '{EV_NONE, 1'b0}},
      '{'{FUNC_TAKE, 1'b0, 32'h0000_0071},   1'b1, '{EV_NONE, 1'b0}}
   };

   button_gesture_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Debounce and gesture behavior for one item; returns the result it owes.
   function automatic rsp_type predict_gesture(input req_type item);
      logic    rise;
      logic    fall;
      rsp_type res;
      rise = 1'b0;
      fall = 1'b0;
      res  = '0;
      case (item.func)
         FUNC_POLL: begin
            // A raw change restarts the settle timer; a steady level is accepted later.
            if (item.raw_pressed != pin_prev) begin
               pin_prev      = item.raw_pressed;
               pin_change_ms = item.now_ms;
            end else if (item.raw_pressed != pin_stable &&
                         (item.now_ms - pin_change_ms) >= {16'd0, cfg_debounce}) begin
               pin_stable = item.raw_pressed;
               rise       = item.raw_pressed;
               fall       = !item.raw_pressed;
            end
            case (ges_phase)
               PH_PRESSED: begin
                  // A release beats the long press timer on the same poll.
                  if (fall) begin
                     ges_release_ms = item.now_ms;
                     ges_phase      = PH_WAIT_SECOND;
                  end else if ((item.now_ms - ges_press_ms) >= {16'd0, cfg_long}) begin
                     ges_event = EV_LONG;
                     ges_phase = PH_LONG_HELD;
                  end
               end
               PH_LONG_HELD, PH_WAIT_RELEASE: begin
                  if (fall) ges_phase = PH_IDLE;
               end
               PH_WAIT_SECOND: begin
                  if (rise) begin
                     ges_event = EV_DOUBLE;
                     ges_phase = PH_WAIT_RELEASE;
                  end else if ((item.now_ms - ges_release_ms) >= {16'd0, cfg_gap}) begin
                     ges_event = EV_SINGLE;
                     ges_phase = PH_IDLE;
                  end
               end
               default: begin
                  ges_phase = PH_IDLE;
                  if (rise) begin
                     ges_press_ms = item.now_ms;
                     ges_phase    = PH_PRESSED;
                  end
               end
            endcase
         end
         FUNC_TAKE: begin
            res.event_res = ges_event;
            ges_event     = EV_NONE;
         end
         FUNC_INIT: begin
            pin_prev      = item.raw_pressed;
            pin_stable    = item.raw_pressed;
            pin_change_ms = item.now_ms;
            ges_phase     = PH_IDLE;
            ges_event     = EV_NONE;
         end
         default: ;
      endcase
      res.active = (ges_phase != PH_IDLE) || (pin_prev != pin_stable);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Offer one item, keeping valid high across a burst and sometimes idling between bursts.
   task automatic send_item(input req_type item, input logic typed_ok, input rsp_type typed_rsp);
      int unsigned gap_len;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_len != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap_len - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= item;
      row_has_rsp = typed_ok;
      row_rsp     = typed_rsp;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Command at the running millisecond count, moved forward first.
   task automatic send_cmd(input logic [1:0] func, input logic raw, input int unsigned advance);
      req_type item;
      tick_ms          = tick_ms + advance;
      item.func        = func;
      item.raw_pressed = raw;
      item.now_ms      = tick_ms;
      send_item(item, 1'b0, '0);
   endtask

   // Hold the pin at one level for about span ms, with bounce and stray commands mixed in.
   task automatic hold_level(input logic lvl, input int unsigned span);
      int unsigned polls;
      int unsigned step;
      int unsigned k;
      polls     = $urandom_range(1, 5);
      step      = span / polls + 1;
      raw_level = lvl;
      if ($urandom_range(0, 3) == 0) send_cmd(FUNC_POLL, !lvl, $urandom_range(0, 2));
      send_cmd(FUNC_POLL, lvl, $urandom_range(0, 2));
      for (k = 0; k < polls; k++) begin
         send_cmd(FUNC_POLL, lvl, step);
         case ($urandom_range(0, 39))
            0, 1, 2, 3, 4, 5: send_cmd(FUNC_TAKE, lvl, $urandom_range(0, 1));
            6:                send_cmd(FUNC_INIT, lvl, 0);
            7:                send_cmd(FUNC_NOP, !lvl, 0);
            default: ;
         endcase
      end
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // A span tiny, under, or just over a limit, so both sides of each timer get hit.
   function automatic int unsigned pick_span(input int unsigned limit);
      int unsigned span;
      case ($urandom_range(0, 3))
         0:       span = $urandom_range(0, 3);
         1:       span = limit + $urandom_range(0, limit / 4 + 3);
         default: span = $urandom_range(0, limit);
      endcase
      return span;
   endfunction

   // Receiver stall pattern: free-running, light, heavy, or long bursts, changed now and then.
   always @(negedge clock) begin
      if (stall_epoch == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_epoch = $urandom_range(20, 200);
      end
      stall_epoch--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_burst != 0) begin
               rsp_stall <= 1'b1;
               stall_burst--;
            end else begin
               rsp_stall <= 1'b0;
               stall_burst = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // Predict on every accepted item, check every accepted result, follow register writes.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         cfg_debounce   = DEBOUNCE_RESET;
         cfg_long       = LONG_PRESS_RESET;
         cfg_gap        = DOUBLE_GAP_RESET;
         pin_stable     = 1'b0;
         pin_prev       = 1'b0;
         pin_change_ms  = '0;
         ges_phase      = PH_IDLE;
         ges_press_ms   = '0;
         ges_release_ms = '0;
         ges_event      = EV_NONE;
         due_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               report_mismatch($sformatf("unexpected item: event %0d active %0d",
                                         rsp_data.event_res, rsp_data.active));
            end else begin
               want = due_reports.pop_front();
               if (rsp_data.event_res !== want.event_res)
                  report_mismatch($sformatf("event_res %0d, wanted %0d",
                                            rsp_data.event_res, want.event_res));
               if (rsp_data.active !== want.active)
                  report_mismatch($sformatf("active %0d, wanted %0d",
                                            rsp_data.active, want.active));
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_gesture(req_data);
            if (row_has_rsp) want = row_rsp;
            due_reports.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEBOUNCE:   cfg_debounce = csr_wdata;
               CSR_LONG_PRESS: cfg_long     = csr_wdata;
               CSR_DOUBLE_GAP: cfg_gap      = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   initial begin
      int unsigned phase_idx;
      int unsigned phase_start;
      int unsigned pick;
      int unsigned presses;
      int unsigned p;
      int unsigned set_debounce;
      int unsigned set_long;
      int unsigned set_gap;
      int unsigned waited;
      req_type     noise;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed_ok, directed_rows[i].typed_rsp);

      for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
         // Let the block run dry before the registers change.
         @(negedge clock);
         req_valid <= 1'b0;
         burst_left = 0;
         while (due_reports.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);

         case (phase_idx)
            1: begin
               set_debounce = 0;
               set_long     = 0;
               set_gap      = 0;
            end
            3: begin
               set_debounce = 32'hFFFF;
               set_long     = 32'hFFFF;
               set_gap      = 32'hFFFF;
            end
            4: begin
               set_debounce = $urandom_range(0, 16'hFFFF);
               set_long     = $urandom_range(0, 16'hFFFF);
               set_gap      = $urandom_range(0, 16'hFFFF);
            end
            6: begin
               set_debounce = 32'(DEBOUNCE_RESET);
               set_long     = 32'(LONG_PRESS_RESET);
               set_gap      = 32'(DOUBLE_GAP_RESET);
            end
            default: begin
               set_debounce = $urandom_range(0, 30);
               set_long     = $urandom_range(20, 400);
               set_gap      = $urandom_range(10, 300);
            end
         endcase
         write_csr(CSR_DEBOUNCE, 16'(set_debounce));
         write_csr(CSR_LONG_PRESS, 16'(set_long));
         write_csr(CSR_DOUBLE_GAP, 16'(set_gap));
         write_csr(CSR_UNUSED, 16'($urandom()));

         // Some phases start just short of the counter wrap.
         if ($urandom_range(0, 2) == 0) tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         else tick_ms = $urandom();

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // Well-formed gesture: one to three presses, short or long, close or apart.
               presses = $urandom_range(1, 3);
               for (p = 0; p < presses; p++) begin
                  hold_level(1'b1, set_debounce + pick_span(set_long));
                  if (p + 1 < presses) hold_level(1'b0, set_debounce + pick_span(set_gap));
                  else hold_level(1'b0, set_debounce + set_gap + pick_span(set_gap));
               end
               if ($urandom_range(0, 1) == 0) send_cmd(FUNC_TAKE, raw_level, 0);
            end else if (pick < 85) begin
               // Noise: any command, any level, any time.
               repeat ($urandom_range(1, 4)) begin
                  noise.func        = 2'($urandom_range(0, 3));
                  noise.raw_pressed = 1'($urandom_range(0, 1));
                  noise.now_ms      = $urandom();
                  send_item(noise, 1'b0, '0);
               end
            end else begin
               hold_level(raw_level, pick_span(set_debounce + set_gap));
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (due_reports.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (due_reports.size() != 0)
         report_mismatch($sformatf("%0d items never came back", due_reports.size()));
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bgd_pkg.sv
rtl/bgd_csr.sv
rtl/bgd_core.sv
rtl/button_gesture_detector.sv
tb/sv/button_gesture_detector_tb.sv
